@@ hdl/ecp_pkg.sv @@
package ecp_pkg;

  // Field widths of one particle pair and of one result.
  localparam int PosW  = 24;
  localparam int VelW  = 24;
  localparam int MassW = 16;
  localparam int RadW  = 20;

  // Derived datapath widths.
  localparam int DiffW = PosW + 1;             // centre difference
  localparam int SqW   = 2 * DiffW;            // one squared difference
  localparam int RsW   = RadW + 1;             // radius sum
  localparam int Rs2W  = 2 * RsW;              // squared radius sum
  localparam int MsW   = MassW + 1;            // mass sum and mass difference
  localparam int ProdW = MsW + VelW;           // mass times velocity
  localparam int NumW  = ProdW + 2;            // signed numerator
  localparam int MagW  = NumW - 1;             // numerator magnitude
  localparam int QW    = 25;                   // quotient bits, |q| <= 3 * 2^23
  localparam int RemW  = MsW;                  // partial remainder

  // Division pipeline shape.
  localparam int DivBits   = 5;
  localparam int DivStages = QW / DivBits;
  localparam int FrontStages = 4;
  localparam int NumStages   = FrontStages + DivStages + 1;

  // Lanes: first x, first y, second x, second y.
  localparam int NLane = 4;
  localparam int LaneAx = 0;
  localparam int LaneAy = 1;
  localparam int LaneBx = 2;
  localparam int LaneBy = 3;

  localparam logic signed [VelW-1:0] VelMax = {1'b0, {(VelW-1){1'b1}}};
  localparam logic signed [VelW-1:0] VelMin = {1'b1, {(VelW-1){1'b0}}};

  typedef logic signed [VelW-1:0] vel_t;
  typedef vel_t [NLane-1:0] vel_vec_t;

  // One lane of the shift-subtract divider.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QW-1:0]   work;
    logic            neg;
  } div_lane_t;

  typedef div_lane_t [NLane-1:0] lane_vec_t;

  // Per-item control that travels beside the divider lanes.
  typedef struct packed {
    logic           hit;
    logic           div_ok;
    logic [MsW-1:0] msum;
    vel_vec_t       vel;
  } side_t;

  // One input pair, unpacked.
  typedef struct packed {
    logic signed [PosW-1:0] a_pos_x;
    logic signed [PosW-1:0] a_pos_y;
    logic signed [VelW-1:0] a_vel_x;
    logic signed [VelW-1:0] a_vel_y;
    logic [MassW-1:0]       a_mass;
    logic [RadW-1:0]        a_radius;
    logic signed [PosW-1:0] b_pos_x;
    logic signed [PosW-1:0] b_pos_y;
    logic signed [VelW-1:0] b_vel_x;
    logic signed [VelW-1:0] b_vel_y;
    logic [MassW-1:0]       b_mass;
    logic [RadW-1:0]        b_radius;
  } pair_t;

endpackage

@@ hdl/ecp_front.sv @@
module ecp_front (
  input  logic              clk,
  input  logic              en,
  input  ecp_pkg::pair_t    pair,
  output ecp_pkg::lane_vec_t lanes,
  output ecp_pkg::side_t    side
);
  import ecp_pkg::*;

  // Stage 1: differences and sums.
  logic signed [DiffW-1:0] s1_dx, s1_dy;
  logic [RsW-1:0]          s1_rs;
  logic signed [MsW-1:0]   s1_dma, s1_dmb;
  logic [MassW-1:0]        s1_am, s1_bm;
  logic [MsW-1:0]          s1_msum;
  vel_vec_t                s1_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= {pair.a_pos_x[PosW-1], pair.a_pos_x} - {pair.b_pos_x[PosW-1], pair.b_pos_x};
      s1_dy   <= {pair.a_pos_y[PosW-1], pair.a_pos_y} - {pair.b_pos_y[PosW-1], pair.b_pos_y};
      s1_rs   <= {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
      s1_dma  <= $signed({1'b0, pair.a_mass}) - $signed({1'b0, pair.b_mass});
      s1_dmb  <= $signed({1'b0, pair.b_mass}) - $signed({1'b0, pair.a_mass});
      s1_am   <= pair.a_mass;
      s1_bm   <= pair.b_mass;
      s1_msum <= {1'b0, pair.a_mass} + {1'b0, pair.b_mass};
      s1_vel[LaneAx] <= pair.a_vel_x;
      s1_vel[LaneAy] <= pair.a_vel_y;
      s1_vel[LaneBx] <= pair.b_vel_x;
      s1_vel[LaneBy] <= pair.b_vel_y;
    end
  end

  // Stage 2: all products, one multiplier per path.
  logic signed [SqW-1:0]  s2_dx2, s2_dy2;
  logic [Rs2W-1:0]        s2_rs2;
  logic signed [ProdW-1:0] s2_p0 [NLane];
  logic signed [ProdW-1:0] s2_p1 [NLane];
  logic [MsW-1:0]         s2_msum;
  vel_vec_t               s2_vel;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx2 <= s1_dx * s1_dx;
      s2_dy2 <= s1_dy * s1_dy;
      s2_rs2 <= s1_rs * s1_rs;
      s2_p0[LaneAx] <= s1_dma * s1_vel[LaneAx];
      s2_p0[LaneAy] <= s1_dma * s1_vel[LaneAy];
      s2_p0[LaneBx] <= s1_dmb * s1_vel[LaneBx];
      s2_p0[LaneBy] <= s1_dmb * s1_vel[LaneBy];
      s2_p1[LaneAx] <= $signed({1'b0, s1_bm}) * s1_vel[LaneBx];
      s2_p1[LaneAy] <= $signed({1'b0, s1_bm}) * s1_vel[LaneBy];
      s2_p1[LaneBx] <= $signed({1'b0, s1_am}) * s1_vel[LaneAx];
      s2_p1[LaneBy] <= $signed({1'b0, s1_am}) * s1_vel[LaneAy];
      s2_msum <= s1_msum;
      s2_vel  <= s1_vel;
    end
  end

  // Stage 3: contact compare and numerators.
  logic                   s3_hit;
  logic signed [NumW-1:0] s3_num [NLane];
  logic [MsW-1:0]         s3_msum;
  vel_vec_t               s3_vel;
  logic [SqW:0]           d2;

  assign d2 = {1'b0, s2_dx2[SqW-1:0]} + {1'b0, s2_dy2[SqW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_hit <= d2 <= (SqW+1)'(s2_rs2);
      for (int l = 0; l < NLane; l++) begin
        s3_num[l] <= NumW'(s2_p0[l]) + (NumW'(s2_p1[l]) <<< 1);
      end
      s3_msum <= s2_msum;
      s3_vel  <= s2_vel;
    end
  end

  // Stage 4: sign and magnitude, loaded into the divider lanes.
  logic [MagW-1:0] mag [NLane];

  always_comb begin
    for (int l = 0; l < NLane; l++) begin
      mag[l] = s3_num[l][NumW-1] ? MagW'(-s3_num[l]) : MagW'(s3_num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLane; l++) begin
        lanes[l].rem  <= mag[l][MagW-1:QW];
        lanes[l].work <= mag[l][QW-1:0];
        lanes[l].neg  <= s3_num[l][NumW-1];
      end
      side.hit    <= s3_hit;
      side.div_ok <= s3_msum != '0;
      side.msum   <= s3_msum;
      side.vel    <= s3_vel;
    end
  end

endmodule

@@ hdl/ecp_div_stage.sv @@
module ecp_div_stage (
  input  logic                clk,
  input  logic                en,
  input  logic [ecp_pkg::MsW-1:0] divisor,
  input  ecp_pkg::lane_vec_t  lanes_in,
  output ecp_pkg::lane_vec_t  lanes_out
);
  import ecp_pkg::*;

  lane_vec_t lanes_next;

  // DivBits restoring shift-subtract steps per lane; lanes are independent.
  always_comb begin
    logic [RemW:0] r;
    logic          q;
    div_lane_t     cur;
    for (int l = 0; l < NLane; l++) begin
      cur = lanes_in[l];
      for (int s = 0; s < DivBits; s++) begin
        r = {cur.rem, cur.work[QW-1]};
        q = r >= {1'b0, divisor};
        if (q) begin
          cur.rem = RemW'(r - {1'b0, divisor});
        end else begin
          cur.rem = r[RemW-1:0];
        end
        cur.work = {cur.work[QW-2:0], q};
      end
      lanes_next[l] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_out <= lanes_next;
    end
  end

endmodule

@@ hdl/ecp_back.sv @@
module ecp_back (
  input  logic               clk,
  input  logic               en,
  input  ecp_pkg::lane_vec_t lanes,
  input  ecp_pkg::side_t     side,
  output ecp_pkg::vel_vec_t  vel_out,
  output logic               hit_out
);
  import ecp_pkg::*;

  vel_vec_t vel_next;

  // Restore the sign, saturate, and pick the bounced or unchanged velocity.
  always_comb begin
    logic [QW-1:0] q;
    vel_t          sat;
    for (int l = 0; l < NLane; l++) begin
      q = lanes[l].work;
      if (!lanes[l].neg) begin
        sat = (q > QW'(VelMax)) ? VelMax : vel_t'(q);
      end else begin
        sat = (q > QW'({1'b0, VelMin})) ? VelMin : vel_t'(-q);
      end
      vel_next[l] = (side.hit && side.div_ok) ? sat : side.vel[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_out <= vel_next;
      hit_out <= side.hit;
    end
  end

endmodule

@@ hdl/elastic_collision_pair.sv @@
// Throughput: one pair per cycle when not stalled; four front stages, five divider
// stages of five quotient bits each, and one output stage.
// Back pressure stalls the whole pipeline together; nothing is lost or repeated.
// Reset (synchronous, active high) clears the stage valid bits only.
module elastic_collision_pair (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass, a_radius,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass, b_radius
  input  logic [263:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
  output logic [95:0]  m_tdata,
  // collided
  output logic         m_tuser
);
  import ecp_pkg::*;

  logic                 en;
  logic [NumStages-1:0] vld;
  pair_t                pair;
  lane_vec_t            lanes [DivStages+1];
  side_t                side  [DivStages+1];
  vel_vec_t             vel_out;
  logic                 hit_out;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !vld[NumStages-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], s_tvalid};
    end
  end

  // Unpack the input beat.
  assign pair.a_pos_x  = s_tdata[23:0];
  assign pair.a_pos_y  = s_tdata[47:24];
  assign pair.a_vel_x  = s_tdata[71:48];
  assign pair.a_vel_y  = s_tdata[95:72];
  assign pair.a_mass   = s_tdata[111:96];
  assign pair.a_radius = s_tdata[131:112];
  assign pair.b_pos_x  = s_tdata[155:132];
  assign pair.b_pos_y  = s_tdata[179:156];
  assign pair.b_vel_x  = s_tdata[203:180];
  assign pair.b_vel_y  = s_tdata[227:204];
  assign pair.b_mass   = s_tdata[243:228];
  assign pair.b_radius = s_tdata[263:244];

  ecp_front u_front (
    .clk   (clk),
    .en    (en),
    .pair  (pair),
    .lanes (lanes[0]),
    .side  (side[0])
  );

  // Divider stages, with the per-item control delayed beside them.
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    ecp_div_stage u_stage (
      .clk       (clk),
      .en        (en),
      .divisor   (side[g].msum),
      .lanes_in  (lanes[g]),
      .lanes_out (lanes[g+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        side[g+1] <= side[g];
      end
    end
  end

  ecp_back u_back (
    .clk     (clk),
    .en      (en),
    .lanes   (lanes[DivStages]),
    .side    (side[DivStages]),
    .vel_out (vel_out),
    .hit_out (hit_out)
  );

  // Pack the output beat.
  assign m_tdata = {vel_out[LaneBy], vel_out[LaneBx], vel_out[LaneAy], vel_out[LaneAx]};
  assign m_tuser = hit_out;

endmodule

@@ hdl/ecp_checker.sv @@
module ecp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic         m_tuser
);

  // A stalled output beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat withdrawn while stalled");

  // A stalled output beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // The input side is held off only by a stalled output beat.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // Nothing leaves the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // A stall at the output keeps the input side closed in the same cycle.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

endmodule

bind elastic_collision_pair ecp_checker u_ecp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
